### rtl/fbfl_pkg.sv
`timescale 1ns / 1ps
// fbfl_pkg: shared types and constants for the fixed buffer free list.
// No dependencies; imported by fixed_buffer_free_list.
package fbfl_pkg;

    // Default pool geometry
    localparam int DEF_MAX_BUFFERS = 256;
    localparam int DEF_NODE_BYTES  = 16;

    // Fixed field widths
    localparam int CMD_W    = 2;
    localparam int BIDX_W   = 8;
    localparam int ADDR_W   = 32;
    localparam int CNT_W    = 9;
    localparam int FREE_W   = 16;
    localparam int CFG_IDX_W = 1;

    // Free counter ceiling and reported count ceiling
    localparam logic [FREE_W-1:0] FREE_CAP = 16'hFFFF;
    localparam logic [CNT_W-1:0]  OUT_CAP  = 9'd511;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BYTES = 1'b1;

    // Commands
    typedef enum logic [CMD_W-1:0] {
        CMD_BUILD   = 2'd0,
        CMD_ALLOC   = 2'd1,
        CMD_RELEASE = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    // Control states, one-hot
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ALLOC  = 4'b0010,
        S_FINISH = 4'b0100,
        S_BUILD  = 4'b1000
    } t_state;

endpackage

### rtl/fbfl_link_ram.sv
`timescale 1ns / 1ps
// fbfl_link_ram: next-index link memory, one write port, one registered read port.
// Depends on nothing beyond its parameters.
module fbfl_link_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8,
    parameter int DW    = 9
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/fixed_buffer_free_list.sv
`timescale 1ns / 1ps
// Pool of fixed-size buffers kept as a LIFO free list in a next-index link memory.
// An allocate reads the link memory at the head when accepted and takes the new head
// from the registered read data in S_ALLOC; a release or unused command goes through
// S_FINISH. A build walks the link memory one entry per cycle through its single write
// port, linking as many buffers as fit, then loads its result. One command is in flight
// at a time; the next is accepted as soon as the result sits in the output register,
// while that result may still wait to be taken. The link memory needs no clearing pass
// after reset, since no command can read an entry that was not first written.
// Depends on fbfl_pkg and fbfl_link_ram.
module fixed_buffer_free_list #(
    parameter int MAX_BUFFERS = fbfl_pkg::DEF_MAX_BUFFERS,
    parameter int NODE_BYTES  = fbfl_pkg::DEF_NODE_BYTES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_we,
    input  logic [fbfl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [fbfl_pkg::ADDR_W-1:0]      i_cfg_data,
    // command channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [fbfl_pkg::CMD_W-1:0]       i_command,
    input  logic [fbfl_pkg::BIDX_W-1:0]      i_buffer_index,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_ok,
    output logic [fbfl_pkg::BIDX_W-1:0]      o_granted_index,
    output logic [fbfl_pkg::ADDR_W-1:0]      o_granted_address,
    output logic [fbfl_pkg::CNT_W-1:0]       o_free_count,
    output logic [fbfl_pkg::CNT_W-1:0]       o_total_count
);
    import fbfl_pkg::*;

    localparam int AW = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
    localparam int LW = $clog2(MAX_BUFFERS + 1);
    localparam logic [LW-1:0]     LIST_EMPTY = LW'(MAX_BUFFERS);
    localparam logic [LW-1:0]     LAST_IDX   = LW'(MAX_BUFFERS - 1);
    localparam logic [ADDR_W-1:0] NODE_B     = ADDR_W'(NODE_BYTES);
    localparam logic [ADDR_W-1:0] TWO_NODE_B = ADDR_W'(2 * NODE_BYTES);

    // Configuration registers
    logic [ADDR_W-1:0] r_region_base;
    logic [ADDR_W-1:0] r_region_bytes;

    // Control and list state
    t_state            r_state, n_state;
    logic [LW-1:0]     r_head, n_head;
    logic [FREE_W-1:0] r_free, n_free;
    logic [LW-1:0]     r_pool, n_pool;
    logic [ADDR_W-1:0] r_abase, n_abase;

    // Per-command working registers
    t_cmd              r_cmd, n_cmd;
    logic [BIDX_W-1:0] r_idx, n_idx;
    logic [ADDR_W-1:0] r_off, n_off;
    logic [ADDR_W-1:0] r_rem, n_rem;
    logic [LW-1:0]     r_bidx, n_bidx;

    // Output register
    logic              r_out_valid;
    logic              r_ok;
    logic [BIDX_W-1:0] r_gidx;
    logic [ADDR_W-1:0] r_gaddr;
    logic [CNT_W-1:0]  r_free_cnt;
    logic [CNT_W-1:0]  r_total_cnt;

    // Link memory port signals
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [LW-1:0] w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr;
    logic [LW-1:0] w_rdata;

    // Datapath helpers
    logic              w_slot_free;
    logic              w_load;
    logic              w_res_ok;
    logic [BIDX_W-1:0] w_res_gidx;
    logic [ADDR_W-1:0] w_res_gaddr;
    logic [ADDR_W-1:0] w_abase;
    logic [1:0]        w_pad;
    logic [ADDR_W-1:0] w_rest;
    logic              w_more;
    logic              w_last;
    logic              w_in_pool;

    fbfl_link_ram #(
        .DEPTH (MAX_BUFFERS),
        .AW    (AW),
        .DW    (LW)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_slot_free = !r_out_valid || i_out_ready;

    // Alignment of the region and the usable size
    assign w_abase = (r_region_base + ADDR_W'(3)) & ~ADDR_W'(3);
    assign w_pad   = 2'(2'd0 - r_region_base[1:0]);
    assign w_rest  = (r_region_bytes >= ADDR_W'(w_pad)) ?
                     (r_region_bytes - ADDR_W'(w_pad)) : '0;

    // Build walk: one more node fits, and whether it is the final one
    assign w_more = (r_rem >= NODE_B) && (r_bidx != LIST_EMPTY);
    assign w_last = (r_rem < TWO_NODE_B) || (r_bidx == LAST_IDX);

    assign w_in_pool = (32'(r_idx) < 32'(r_pool));

    // Command sequencing
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_free      = r_free;
        n_pool      = r_pool;
        n_abase     = r_abase;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_off       = r_off;
        n_rem       = r_rem;
        n_bidx      = r_bidx;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_wdata     = '0;
        w_re        = 1'b0;
        w_raddr     = AW'(r_head);
        w_load      = 1'b0;
        w_res_ok    = 1'b0;
        w_res_gidx  = '0;
        w_res_gaddr = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd = t_cmd'(i_command);
                    n_idx = i_buffer_index;
                    n_off = ADDR_W'(r_head) * NODE_B;
                    case (t_cmd'(i_command))
                        CMD_BUILD: begin
                            n_abase = w_abase;
                            n_rem   = w_rest;
                            n_bidx  = '0;
                            n_state = S_BUILD;
                        end
                        CMD_ALLOC: begin
                            w_re    = (r_head != LIST_EMPTY);
                            n_state = S_ALLOC;
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                if (w_slot_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                    if (r_head != LIST_EMPTY) begin
                        // pop: new head from the link, old head marked as taken
                        w_res_ok    = 1'b1;
                        w_res_gidx  = BIDX_W'(r_head);
                        w_res_gaddr = r_abase + r_off;
                        n_head      = w_rdata;
                        w_we        = 1'b1;
                        w_waddr     = AW'(r_head);
                        w_wdata     = LIST_EMPTY;
                        n_free      = (r_free != '0) ? (r_free - 1'b1) : r_free;
                    end
                end
            end
            S_FINISH: begin
                if (w_slot_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                    if ((r_cmd == CMD_RELEASE) && w_in_pool) begin
                        // push onto the head
                        w_res_ok = 1'b1;
                        w_we     = 1'b1;
                        w_waddr  = AW'(r_idx);
                        w_wdata  = r_head;
                        n_head   = LW'(r_idx);
                        n_free   = (r_free != FREE_CAP) ? (r_free + 1'b1) : r_free;
                    end
                end
            end
            S_BUILD: begin
                if (w_more) begin
                    w_we    = 1'b1;
                    w_waddr = AW'(r_bidx);
                    w_wdata = w_last ? LIST_EMPTY : (r_bidx + 1'b1);
                    n_rem   = r_rem - NODE_B;
                    n_bidx  = r_bidx + 1'b1;
                end else if (w_slot_free) begin
                    w_load   = 1'b1;
                    n_state  = S_IDLE;
                    w_res_ok = (r_bidx != '0);
                    n_pool   = r_bidx;
                    n_free   = FREE_W'(r_bidx);
                    n_head   = (r_bidx == '0) ? LIST_EMPTY : '0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_base  <= '0;
            r_region_bytes <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REGION_BASE:  r_region_base  <= i_cfg_data;
                CFG_REGION_BYTES: r_region_bytes <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= LIST_EMPTY;
            r_free      <= '0;
            r_pool      <= '0;
            r_abase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_free  <= n_free;
            r_pool  <= n_pool;
            r_abase <= n_abase;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working and result payload
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_idx  <= n_idx;
        r_off  <= n_off;
        r_rem  <= n_rem;
        r_bidx <= n_bidx;
        if (w_load) begin
            r_ok        <= w_res_ok;
            r_gidx      <= w_res_gidx;
            r_gaddr     <= w_res_gaddr;
            r_free_cnt  <= (n_free > FREE_W'(OUT_CAP)) ? OUT_CAP : CNT_W'(n_free);
            r_total_cnt <= (32'(n_pool) > 32'(OUT_CAP)) ? OUT_CAP : CNT_W'(n_pool);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_ok              = r_ok;
    assign o_granted_index   = r_gidx;
    assign o_granted_address = r_gaddr;
    assign o_free_count      = r_free_cnt;
    assign o_total_count     = r_total_cnt;

    // Checks
    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pool) <= 32'(MAX_BUFFERS))
        else $error("pool size above capacity");

    a_head_needs_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head != LIST_EMPTY) |-> (r_pool != '0))
        else $error("list head set with an empty pool");

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !w_we)
        else $error("link memory written while idle");

    a_alloc_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ALLOC) && $past(r_state == S_IDLE) && (r_head != LIST_EMPTY))
        |-> $past(w_re))
        else $error("allocate without link read");

    a_build_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_BUILD) && w_we) |-> (r_bidx != LIST_EMPTY))
        else $error("build write beyond pool");

endmodule
